### hdl/assert_macros.svh
// Assertion macros shared by the transaction machine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define CTG_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CTG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ctg_pkg.sv
// Package for the coherence transaction graph machine: node, event, action codes,
// the flattened edge table and lookup helpers. No dependencies.
package ctg_pkg;

    localparam int CallStackDepthDef = 4;
    localparam int NumEdges          = 17;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // graph select codes
    localparam logic [1:0] GS_READ_UNIQUE = 2'd0;
    localparam logic [1:0] GS_CLEAN_INV   = 2'd1;
    localparam logic [1:0] GS_MC_READ     = 2'd2;
    localparam logic [1:0] GS_SNP_CI      = 2'd3;

    // node codes
    localparam logic [3:0] N_MC_ENTRY    = 4'd0;
    localparam logic [3:0] N_MC_WAIT_RR  = 4'd1;
    localparam logic [3:0] N_MC_WAIT_CD  = 4'd2;
    localparam logic [3:0] N_MC_EXIT     = 4'd3;
    localparam logic [3:0] N_SCI_ENTRY   = 4'd4;
    localparam logic [3:0] N_SCI_WAIT    = 4'd5;
    localparam logic [3:0] N_SCI_EXIT    = 4'd6;
    localparam logic [3:0] N_RU_ENTRY    = 4'd7;
    localparam logic [3:0] N_RU_SLC      = 4'd8;
    localparam logic [3:0] N_RU_CALL_MC  = 4'd9;
    localparam logic [3:0] N_RU_WAIT_ACK = 4'd10;
    localparam logic [3:0] N_RU_EXIT     = 4'd11;
    localparam logic [3:0] N_CI_ENTRY    = 4'd12;
    localparam logic [3:0] N_CI_SLC      = 4'd13;
    localparam logic [3:0] N_CI_CALL_SCI = 4'd14;
    localparam logic [3:0] N_CI_EXIT     = 4'd15;

    // event codes
    localparam logic [2:0] EV_ENTER     = 3'd0;
    localparam logic [2:0] EV_SUBDONE   = 3'd1;
    localparam logic [2:0] EV_SLC_DONE  = 3'd2;
    localparam logic [2:0] EV_READ_RCPT = 3'd3;
    localparam logic [2:0] EV_COMP_DATA = 3'd4;
    localparam logic [2:0] EV_COMP_ACK  = 3'd5;
    localparam logic [2:0] EV_SNP_RESP  = 3'd6;

    // node kinds
    localparam logic [1:0] K_STATE     = 2'd0;
    localparam logic [1:0] K_COMPOSITE = 2'd1;
    localparam logic [1:0] K_EXIT      = 2'd2;

    // guards
    localparam logic [2:0] G_ALWAYS    = 3'd0;
    localparam logic [2:0] G_SLC_HIT   = 3'd1;
    localparam logic [2:0] G_MISS_MISS = 3'd2;
    localparam logic [2:0] G_HIT_HIT   = 3'd3;
    localparam logic [2:0] G_MISS_HIT  = 3'd4;
    localparam logic [2:0] G_HIT_MISS  = 3'd5;
    localparam logic [2:0] G_ORD_NZ    = 3'd6;
    localparam logic [2:0] G_ORD_Z     = 3'd7;

    // actions
    localparam logic [2:0] A_START_SLC     = 3'd0;
    localparam logic [2:0] A_READ_NO_SNP   = 3'd1;
    localparam logic [2:0] A_COMP_ACK      = 3'd2;
    localparam logic [2:0] A_COMP_DATA     = 3'd3;
    localparam logic [2:0] A_COMP          = 3'd4;
    localparam logic [2:0] A_SNP_MAKE_INV  = 3'd5;
    localparam logic [2:0] A_FLUSH_SF      = 3'd6;
    localparam logic [2:0] A_FLUSH_L3      = 3'd7;

    // targets
    localparam logic TGT_LINK  = 1'b0;
    localparam logic TGT_CACHE = 1'b1;

    typedef struct packed {
        logic [3:0] src;
        logic [2:0] ev;
        logic [2:0] guard;
        logic [3:0] dst;
        logic [1:0] nact;
        logic [2:0] act0;
        logic       tgt0;
        logic [2:0] act1;
        logic       tgt1;
    } t_edge;

    typedef struct packed {
        logic  hit;
        t_edge e;
    } t_hop;

    typedef struct packed {
        logic       kind;
        logic [1:0] graph_select;
        logic [2:0] event_code;
        logic       slc_hit;
        logic       sf_hit;
        logic       order_nonzero;
    } t_item;

    typedef struct packed {
        logic       transitioned;
        logic       finished;
        logic [3:0] prior_node;
        logic [3:0] next_node;
        logic [1:0] action_count;
        logic [2:0] first_action;
        logic       first_target;
        logic [2:0] second_action;
        logic       second_target;
    } t_result;

    typedef struct packed {
        logic       push;
        logic [3:0] push_node;
    } t_stack_ctl;

    localparam t_edge EdgeTable [NumEdges] = '{
        '{N_MC_ENTRY, EV_ENTER, G_ORD_NZ, N_MC_WAIT_RR, 2'd1,
          A_READ_NO_SNP, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_MC_ENTRY, EV_ENTER, G_ORD_Z, N_MC_WAIT_CD, 2'd1,
          A_READ_NO_SNP, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_MC_WAIT_RR, EV_READ_RCPT, G_ALWAYS, N_MC_WAIT_CD, 2'd0,
          A_START_SLC, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_MC_WAIT_CD, EV_COMP_DATA, G_ALWAYS, N_MC_EXIT, 2'd1,
          A_COMP_ACK, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_SCI_ENTRY, EV_ENTER, G_ALWAYS, N_SCI_WAIT, 2'd1,
          A_SNP_MAKE_INV, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_SCI_WAIT, EV_SNP_RESP, G_ALWAYS, N_SCI_EXIT, 2'd1,
          A_FLUSH_SF, TGT_CACHE, A_START_SLC, TGT_LINK},
        '{N_RU_ENTRY, EV_ENTER, G_ALWAYS, N_RU_SLC, 2'd1,
          A_START_SLC, TGT_CACHE, A_START_SLC, TGT_LINK},
        '{N_RU_SLC, EV_SLC_DONE, G_SLC_HIT, N_RU_WAIT_ACK, 2'd1,
          A_COMP_DATA, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_RU_SLC, EV_SLC_DONE, G_MISS_MISS, N_RU_CALL_MC, 2'd0,
          A_START_SLC, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_RU_CALL_MC, EV_SUBDONE, G_ALWAYS, N_RU_WAIT_ACK, 2'd1,
          A_COMP_DATA, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_RU_WAIT_ACK, EV_COMP_ACK, G_ALWAYS, N_RU_EXIT, 2'd0,
          A_START_SLC, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_CI_ENTRY, EV_ENTER, G_ALWAYS, N_CI_SLC, 2'd1,
          A_START_SLC, TGT_CACHE, A_START_SLC, TGT_LINK},
        '{N_CI_SLC, EV_SLC_DONE, G_HIT_HIT, N_CI_CALL_SCI, 2'd1,
          A_FLUSH_L3, TGT_CACHE, A_START_SLC, TGT_LINK},
        '{N_CI_SLC, EV_SLC_DONE, G_MISS_HIT, N_CI_CALL_SCI, 2'd0,
          A_START_SLC, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_CI_SLC, EV_SLC_DONE, G_HIT_MISS, N_CI_EXIT, 2'd2,
          A_FLUSH_L3, TGT_CACHE, A_COMP, TGT_LINK},
        '{N_CI_SLC, EV_SLC_DONE, G_MISS_MISS, N_CI_EXIT, 2'd1,
          A_COMP, TGT_LINK, A_START_SLC, TGT_LINK},
        '{N_CI_CALL_SCI, EV_SUBDONE, G_ALWAYS, N_CI_EXIT, 2'd1,
          A_COMP, TGT_LINK, A_START_SLC, TGT_LINK}
    };

    function automatic logic guard_ok(input logic [2:0] g, input logic slc,
                                      input logic sf, input logic ord);
        logic ok;
        unique case (g)
            G_ALWAYS:    ok = 1'b1;
            G_SLC_HIT:   ok = slc;
            G_MISS_MISS: ok = !slc && !sf;
            G_HIT_HIT:   ok = slc && sf;
            G_MISS_HIT:  ok = !slc && sf;
            G_HIT_MISS:  ok = slc && !sf;
            G_ORD_NZ:    ok = ord;
            G_ORD_Z:     ok = !ord;
            default:     ok = 1'b1;
        endcase
        return ok;
    endfunction

    // first matching edge wins
    function automatic t_hop edge_lookup(input logic [3:0] node, input logic [2:0] ev,
                                         input logic slc, input logic sf, input logic ord);
        t_hop h;
        h = '0;
        for (int i = NumEdges - 1; i >= 0; i--) begin
            if (EdgeTable[i].src == node && EdgeTable[i].ev == ev &&
                guard_ok(EdgeTable[i].guard, slc, sf, ord)) begin
                h.hit = 1'b1;
                h.e   = EdgeTable[i];
            end
        end
        return h;
    endfunction

    function automatic logic [1:0] node_kind(input logic [3:0] node);
        logic [1:0] k;
        unique case (node)
            N_MC_EXIT, N_SCI_EXIT, N_RU_EXIT, N_CI_EXIT: k = K_EXIT;
            N_RU_CALL_MC, N_CI_CALL_SCI:                 k = K_COMPOSITE;
            default:                                     k = K_STATE;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] child_entry(input logic [3:0] node);
        return (node == N_CI_CALL_SCI) ? N_SCI_ENTRY : N_MC_ENTRY;
    endfunction

    function automatic logic [3:0] graph_entry(input logic [1:0] sel);
        logic [3:0] n;
        unique case (sel)
            GS_READ_UNIQUE: n = N_RU_ENTRY;
            GS_CLEAN_INV:   n = N_CI_ENTRY;
            GS_MC_READ:     n = N_MC_ENTRY;
            GS_SNP_CI:      n = N_SCI_ENTRY;
        endcase
        return n;
    endfunction

endpackage

### hdl/ctg_step.sv
// Next-state resolver: one item against the current node, with the zero-time
// call and return hops folded in. Depends on ctg_pkg.
module ctg_step #(
    parameter int CALL_STACK_DEPTH = ctg_pkg::CallStackDepthDef,
    localparam int DW = $clog2(CALL_STACK_DEPTH + 1)
) (
    input  ctg_pkg::t_item      i_item,
    input  logic [3:0]          i_node,
    input  logic                i_loaded,
    input  logic                i_done,
    input  logic [DW-1:0]       i_depth,
    input  logic [3:0]          i_top,
    output ctg_pkg::t_result    o_res,
    output logic [3:0]          o_node,
    output logic                o_loaded,
    output logic                o_done,
    output logic [DW-1:0]       o_depth,
    output ctg_pkg::t_stack_ctl o_ctl
);

    localparam logic [DW-1:0] DepthMax = DW'(CALL_STACK_DEPTH);

    ctg_pkg::t_hop hop_a;
    ctg_pkg::t_hop hop_b;
    logic [1:0]    kind_a;
    logic          a_call;
    logic [3:0]    b_node;
    logic [2:0]    b_ev;
    logic          b_attr;
    logic          use_a;
    logic          use_b;
    logic [1:0]    na;
    logic [1:0]    nb;
    logic [2:0]    nsum;

    assign hop_a  = ctg_pkg::edge_lookup(i_node, i_item.event_code, i_item.slc_hit,
                                         i_item.sf_hit, i_item.order_nonzero);
    assign kind_a = ctg_pkg::node_kind(hop_a.e.dst);
    assign a_call = (kind_a == ctg_pkg::K_COMPOSITE);

    // second hop: child entry after a call, or the caller after a return
    assign b_node = a_call ? ctg_pkg::child_entry(hop_a.e.dst) : i_top;
    assign b_ev   = a_call ? ctg_pkg::EV_ENTER : ctg_pkg::EV_SUBDONE;
    assign b_attr = a_call;
    assign hop_b  = ctg_pkg::edge_lookup(b_node, b_ev, i_item.slc_hit & b_attr,
                                         i_item.sf_hit & b_attr,
                                         i_item.order_nonzero & b_attr);

    always_comb begin
        o_res            = '0;
        o_res.prior_node = i_node;
        o_node           = i_node;
        o_loaded         = i_loaded;
        o_done           = i_done;
        o_depth          = i_depth;
        o_ctl            = '0;
        use_a            = 1'b0;
        use_b            = 1'b0;

        if (i_item.kind == ctg_pkg::KIND_START) begin
            o_node   = ctg_pkg::graph_entry(i_item.graph_select);
            o_loaded = 1'b1;
            o_done   = 1'b0;
            o_depth  = '0;
        end else if (i_loaded && !i_done && hop_a.hit) begin
            use_a              = 1'b1;
            o_res.transitioned = 1'b1;
            o_node             = hop_a.e.dst;
            unique case (kind_a)
                ctg_pkg::K_COMPOSITE: begin
                    if (i_depth < DepthMax) begin
                        o_ctl.push      = 1'b1;
                        o_ctl.push_node = hop_a.e.dst;
                        o_depth         = i_depth + DW'(1);
                        o_node          = b_node;
                        if (hop_b.hit) begin
                            use_b  = 1'b1;
                            o_node = hop_b.e.dst;
                        end
                    end
                end
                ctg_pkg::K_EXIT: begin
                    if (i_depth == '0) begin
                        o_done         = 1'b1;
                        o_res.finished = 1'b1;
                    end else begin
                        o_depth = i_depth - DW'(1);
                        o_node  = i_top;
                        if (hop_b.hit) begin
                            use_b  = 1'b1;
                            o_node = hop_b.e.dst;
                            if (ctg_pkg::node_kind(hop_b.e.dst) == ctg_pkg::K_EXIT &&
                                o_depth == '0) begin
                                o_done         = 1'b1;
                                o_res.finished = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // merge actions of both hops into two slots
        na   = use_a ? hop_a.e.nact : 2'd0;
        nb   = use_b ? hop_b.e.nact : 2'd0;
        nsum = {1'b0, na} + {1'b0, nb};
        o_res.action_count = (nsum > 3'd2) ? 2'd2 : nsum[1:0];
        if (na != 2'd0) begin
            o_res.first_action = hop_a.e.act0;
            o_res.first_target = hop_a.e.tgt0;
        end else if (nb != 2'd0) begin
            o_res.first_action = hop_b.e.act0;
            o_res.first_target = hop_b.e.tgt0;
        end
        if (na == 2'd2) begin
            o_res.second_action = hop_a.e.act1;
            o_res.second_target = hop_a.e.tgt1;
        end else if (na == 2'd1 && nb != 2'd0) begin
            o_res.second_action = hop_b.e.act0;
            o_res.second_target = hop_b.e.tgt0;
        end else if (na == 2'd0 && nb == 2'd2) begin
            o_res.second_action = hop_b.e.act1;
            o_res.second_target = hop_b.e.tgt1;
        end
        o_res.next_node = o_node;
    end

endmodule

### hdl/coherence_transaction_graph_fsm_top.sv
// Top level of the coherence home-node transaction graph machine: input register,
// state and return stack, result register. Depends on ctg_pkg and ctg_step.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------------------------------
//   in      | i_valid | o_stall | i_kind, i_graph_select, i_event_code, guards
//   out     | o_valid | i_stall | o_transitioned .. o_second_target
//
// One item per cycle sustained while i_stall is low.
// Each item resolves combinationally between the input and result registers;
// the node, stack depth and return stack update as it moves into the result register.
// Reset clears both valids and the machine state; return stack entries are not reset.
// A stalled result holds; o_stall rises only when the input register cannot drain.
module coherence_transaction_graph_fsm_top #(
    parameter int CALL_STACK_DEPTH = ctg_pkg::CallStackDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [1:0] i_graph_select,
    input  logic [2:0] i_event_code,
    input  logic       i_slc_hit,
    input  logic       i_sf_hit,
    input  logic       i_order_nonzero,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_transitioned,
    output logic       o_finished,
    output logic [3:0] o_prior_node,
    output logic [3:0] o_next_node,
    output logic [1:0] o_action_count,
    output logic [2:0] o_first_action,
    output logic       o_first_target,
    output logic [2:0] o_second_action,
    output logic       o_second_target
);

    `include "assert_macros.svh"

    localparam int DW = $clog2(CALL_STACK_DEPTH + 1);
    localparam int IW = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;

    ctg_pkg::t_item      r_in;
    logic                r_in_valid;
    ctg_pkg::t_result    r_res;
    logic                r_out_valid;
    logic [3:0]          r_node;
    logic                r_loaded;
    logic                r_done;
    logic [DW-1:0]       r_depth;
    logic [3:0]          r_stack [CALL_STACK_DEPTH];

    ctg_pkg::t_result    n_res;
    logic [3:0]          n_node;
    logic                n_loaded;
    logic                n_done;
    logic [DW-1:0]       n_depth;
    ctg_pkg::t_stack_ctl stack_ctl;
    logic [3:0]          stack_top;
    logic                accept_in;
    logic                advance;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign accept_in = i_valid && !o_stall;

    assign stack_top = (r_depth == '0) ? 4'd0 : r_stack[IW'(r_depth - DW'(1))];

    ctg_step #(
        .CALL_STACK_DEPTH (CALL_STACK_DEPTH)
    ) u_step (
        .i_item   (r_in),
        .i_node   (r_node),
        .i_loaded (r_loaded),
        .i_done   (r_done),
        .i_depth  (r_depth),
        .i_top    (stack_top),
        .o_res    (n_res),
        .o_node   (n_node),
        .o_loaded (n_loaded),
        .o_done   (n_done),
        .o_depth  (n_depth),
        .o_ctl    (stack_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_node      <= 4'd0;
            r_loaded    <= 1'b0;
            r_done      <= 1'b0;
            r_depth     <= '0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_node      <= n_node;
                r_loaded    <= n_loaded;
                r_done      <= n_done;
                r_depth     <= n_depth;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in.kind          <= i_kind;
            r_in.graph_select  <= i_graph_select;
            r_in.event_code    <= i_event_code;
            r_in.slc_hit       <= i_slc_hit;
            r_in.sf_hit        <= i_sf_hit;
            r_in.order_nonzero <= i_order_nonzero;
        end
        if (advance) begin
            r_res <= n_res;
        end
        if (advance && stack_ctl.push) begin
            r_stack[r_depth[IW-1:0]] <= stack_ctl.push_node;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_transitioned  = r_res.transitioned;
    assign o_finished      = r_res.finished;
    assign o_prior_node    = r_res.prior_node;
    assign o_next_node     = r_res.next_node;
    assign o_action_count  = r_res.action_count;
    assign o_first_action  = r_res.first_action;
    assign o_first_target  = r_res.first_target;
    assign o_second_action = r_res.second_action;
    assign o_second_target = r_res.second_target;

    `CTG_ASSERT(a_depth_bound, r_depth <= DW'(CALL_STACK_DEPTH), "stack depth overflow")
    `CTG_ASSERT_IMP(a_done_loaded, r_done, r_loaded, "done without a loaded graph")
    `CTG_ASSERT_IMP(a_fin_moved, o_valid && o_finished, o_transitioned,
                    "finished without a transition")
    `CTG_ASSERT_NXT(a_start_clears, advance && r_in.kind == ctg_pkg::KIND_START,
                    r_depth == '0 && !r_done && r_loaded, "start did not reset the machine")

endmodule

### tb/tb_coherence_transaction_graph_fsm_top.sv
// Self-checking bench for coherence_transaction_graph_fsm_top: directed and random
// transfers against a local predictor of the graph walk. Depends on ctg_pkg and the RTL.
module tb_coherence_transaction_graph_fsm_top;

    localparam int CallDepth   = ctg_pkg::CallStackDepthDef;
    localparam int ChainLimit  = 32;
    localparam int RandomItems = 850;
    localparam int CycleLimit  = 200000;
    localparam logic [2:0] EV_UNUSED = 3'd7;

    typedef struct packed {
        logic [3:0]                node;
        logic                      loaded;
        logic                      complete;
        logic [CallDepth-1:0][3:0] calls;
        logic [3:0]                depth;
    } t_machine;

    typedef struct packed {
        logic       hit;
        logic [3:0] dst;
        logic [1:0] n;
        logic [2:0] a0;
        logic       t0;
        logic [2:0] a1;
        logic       t1;
    } t_move;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_kind = 1'b0;
    logic [1:0] i_graph_select = '0;
    logic [2:0] i_event_code = '0;
    logic       i_slc_hit = 1'b0;
    logic       i_sf_hit = 1'b0;
    logic       i_order_nonzero = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_transitioned;
    logic       o_finished;
    logic [3:0] o_prior_node;
    logic [3:0] o_next_node;
    logic [1:0] o_action_count;
    logic [2:0] o_first_action;
    logic       o_first_target;
    logic [2:0] o_second_action;
    logic       o_second_target;

    ctg_pkg::t_item   pending_items[$];
    ctg_pkg::t_result expected_steps[$];
    t_machine         gen_state = '0;
    t_machine         dut_state = '0;
    ctg_pkg::t_item   driven_item = '0;
    int       hold_cycles = 0;
    int       stall_cycles = 0;
    int       send_mode = 0;
    int       recv_mode = 0;
    int       failures = 0;
    int       cycles = 0;
    int       n_starts = 0;
    int       n_ignored = 0;
    int       n_completed = 0;
    int       n_dual = 0;
    int       n_nested = 0;

    coherence_transaction_graph_fsm_top i_dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_move move_to(logic [3:0] dst, logic [1:0] n, logic [2:0] a0,
                                      logic t0, logic [2:0] a1, logic t1);
        t_move mv;
        mv = '{1'b1, dst, n, a0, t0, a1, t1};
        return mv;
    endfunction

    function automatic t_move lookup_move(logic [3:0] node, logic [2:0] ev,
                                          logic slc, logic sf, logic ord);
        t_move mv;
        mv = '0;
        case (node)
            ctg_pkg::N_MC_ENTRY: if (ev == ctg_pkg::EV_ENTER)
                mv = move_to(ord ? ctg_pkg::N_MC_WAIT_RR : ctg_pkg::N_MC_WAIT_CD, 2'd1,
                             ctg_pkg::A_READ_NO_SNP, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_MC_WAIT_RR: if (ev == ctg_pkg::EV_READ_RCPT)
                mv = move_to(ctg_pkg::N_MC_WAIT_CD, 2'd0,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_MC_WAIT_CD: if (ev == ctg_pkg::EV_COMP_DATA)
                mv = move_to(ctg_pkg::N_MC_EXIT, 2'd1,
                             ctg_pkg::A_COMP_ACK, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_SCI_ENTRY: if (ev == ctg_pkg::EV_ENTER)
                mv = move_to(ctg_pkg::N_SCI_WAIT, 2'd1,
                             ctg_pkg::A_SNP_MAKE_INV, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_SCI_WAIT: if (ev == ctg_pkg::EV_SNP_RESP)
                mv = move_to(ctg_pkg::N_SCI_EXIT, 2'd1,
                             ctg_pkg::A_FLUSH_SF, ctg_pkg::TGT_CACHE,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_RU_ENTRY: if (ev == ctg_pkg::EV_ENTER)
                mv = move_to(ctg_pkg::N_RU_SLC, 2'd1,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_CACHE,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_RU_SLC: if (ev == ctg_pkg::EV_SLC_DONE) begin
                if (slc)
                    mv = move_to(ctg_pkg::N_RU_WAIT_ACK, 2'd1,
                                 ctg_pkg::A_COMP_DATA, ctg_pkg::TGT_LINK,
                                 ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
                else if (!sf)
                    mv = move_to(ctg_pkg::N_RU_CALL_MC, 2'd0,
                                 ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK,
                                 ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            end
            ctg_pkg::N_RU_CALL_MC: if (ev == ctg_pkg::EV_SUBDONE)
                mv = move_to(ctg_pkg::N_RU_WAIT_ACK, 2'd1,
                             ctg_pkg::A_COMP_DATA, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_RU_WAIT_ACK: if (ev == ctg_pkg::EV_COMP_ACK)
                mv = move_to(ctg_pkg::N_RU_EXIT, 2'd0,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_CI_ENTRY: if (ev == ctg_pkg::EV_ENTER)
                mv = move_to(ctg_pkg::N_CI_SLC, 2'd1,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_CACHE,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            ctg_pkg::N_CI_SLC: if (ev == ctg_pkg::EV_SLC_DONE) begin
                case ({slc, sf})
                    2'b11: mv = move_to(ctg_pkg::N_CI_CALL_SCI, 2'd1,
                                        ctg_pkg::A_FLUSH_L3, ctg_pkg::TGT_CACHE,
                                        ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
                    2'b01: mv = move_to(ctg_pkg::N_CI_CALL_SCI, 2'd0,
                                        ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK,
                                        ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
                    2'b10: mv = move_to(ctg_pkg::N_CI_EXIT, 2'd2,
                                        ctg_pkg::A_FLUSH_L3, ctg_pkg::TGT_CACHE,
                                        ctg_pkg::A_COMP, ctg_pkg::TGT_LINK);
                    default: mv = move_to(ctg_pkg::N_CI_EXIT, 2'd1,
                                          ctg_pkg::A_COMP, ctg_pkg::TGT_LINK,
                                          ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
                endcase
            end
            ctg_pkg::N_CI_CALL_SCI: if (ev == ctg_pkg::EV_SUBDONE)
                mv = move_to(ctg_pkg::N_CI_EXIT, 2'd1,
                             ctg_pkg::A_COMP, ctg_pkg::TGT_LINK,
                             ctg_pkg::A_START_SLC, ctg_pkg::TGT_LINK);
            default: mv = '0;
        endcase
        return mv;
    endfunction

    // one transfer through the machine: start loads an entry, event walks the chain
    function automatic ctg_pkg::t_result advance_machine(inout t_machine m,
                                                         input ctg_pkg::t_item it);
        ctg_pkg::t_result r;
        t_move      mv;
        logic [2:0] ev;
        logic [2:0] act;
        logic       tgt;
        logic       slc;
        logic       sf;
        logic       ord;
        bit         stop;
        r = '0;
        r.prior_node = m.node;
        if (it.kind == ctg_pkg::KIND_START) begin
            case (it.graph_select)
                ctg_pkg::GS_READ_UNIQUE: m.node = ctg_pkg::N_RU_ENTRY;
                ctg_pkg::GS_CLEAN_INV:   m.node = ctg_pkg::N_CI_ENTRY;
                ctg_pkg::GS_MC_READ:     m.node = ctg_pkg::N_MC_ENTRY;
                default:                 m.node = ctg_pkg::N_SCI_ENTRY;
            endcase
            m.loaded = 1'b1;
            m.complete = 1'b0;
            m.calls = '0;
            m.depth = '0;
            r.next_node = m.node;
            return r;
        end
        ev = it.event_code;
        slc = it.slc_hit;
        sf = it.sf_hit;
        ord = it.order_nonzero;
        stop = !m.loaded || m.complete;
        for (int hops = 0; hops < ChainLimit && !stop; hops++) begin
            mv = lookup_move(m.node, ev, slc, sf, ord);
            if (!mv.hit) begin
                stop = 1'b1;
            end else begin
                r.transitioned = 1'b1;
                for (int k = 0; k < mv.n; k++) begin
                    act = (k == 0) ? mv.a0 : mv.a1;
                    tgt = (k == 0) ? mv.t0 : mv.t1;
                    if (r.action_count == 2'd0) begin
                        r.first_action = act;
                        r.first_target = tgt;
                        r.action_count = 2'd1;
                    end else if (r.action_count == 2'd1) begin
                        r.second_action = act;
                        r.second_target = tgt;
                        r.action_count = 2'd2;
                    end
                end
                m.node = mv.dst;
                if (m.node == ctg_pkg::N_RU_CALL_MC || m.node == ctg_pkg::N_CI_CALL_SCI) begin
                    if (m.depth >= CallDepth) begin
                        stop = 1'b1;
                    end else begin
                        m.calls[m.depth] = m.node;
                        m.depth++;
                        m.node = (m.node == ctg_pkg::N_CI_CALL_SCI) ? ctg_pkg::N_SCI_ENTRY
                                                                    : ctg_pkg::N_MC_ENTRY;
                        ev = ctg_pkg::EV_ENTER;
                    end
                end else if (m.node == ctg_pkg::N_MC_EXIT || m.node == ctg_pkg::N_SCI_EXIT ||
                             m.node == ctg_pkg::N_RU_EXIT || m.node == ctg_pkg::N_CI_EXIT) begin
                    if (m.depth == 0) begin
                        m.complete = 1'b1;
                        r.finished = 1'b1;
                        stop = 1'b1;
                    end else begin
                        m.depth--;
                        m.node = m.calls[m.depth];
                        m.calls[m.depth] = '0;
                        ev = ctg_pkg::EV_SUBDONE;
                        slc = 1'b0;
                        sf = 1'b0;
                        ord = 1'b0;
                    end
                end else begin
                    stop = 1'b1;
                end
            end
        end
        r.next_node = m.node;
        return r;
    endfunction

    function automatic logic [2:0] awaited_event(logic [3:0] node);
        case (node)
            ctg_pkg::N_MC_WAIT_RR:                     return ctg_pkg::EV_READ_RCPT;
            ctg_pkg::N_MC_WAIT_CD:                     return ctg_pkg::EV_COMP_DATA;
            ctg_pkg::N_SCI_WAIT:                       return ctg_pkg::EV_SNP_RESP;
            ctg_pkg::N_RU_SLC, ctg_pkg::N_CI_SLC:      return ctg_pkg::EV_SLC_DONE;
            ctg_pkg::N_RU_WAIT_ACK:                    return ctg_pkg::EV_COMP_ACK;
            ctg_pkg::N_RU_CALL_MC, ctg_pkg::N_CI_CALL_SCI: return ctg_pkg::EV_SUBDONE;
            default:                                   return ctg_pkg::EV_ENTER;
        endcase
    endfunction

    function automatic int draw_wait(inout int mode);
        if ($urandom_range(0, 31) == 0)
            mode = $urandom_range(0, 2);
        case (mode)
            1:       return $urandom_range(0, 16);
            2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default: return 0;
        endcase
    endfunction

    task automatic queue_item(ctg_pkg::t_item it);
        void'(advance_machine(gen_state, it));
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic dir(logic kind, logic [1:0] gs, logic [2:0] ev,
                       logic slc, logic sf, logic ord);
        queue_item(ctg_pkg::t_item'{kind, gs, ev, slc, sf, ord});
    endtask

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got,
                               logic [3:0] prior);
        if (got !== want)
            note_failure($sformatf("%s expected %0d got %0d (prior node %0d)",
                                   name, want, got, prior));
    endtask

    task automatic check_step();
        ctg_pkg::t_result got;
        ctg_pkg::t_result want;
        got = {o_transitioned, o_finished, o_prior_node, o_next_node, o_action_count,
               o_first_action, o_first_target, o_second_action, o_second_target};
        if (expected_steps.size() == 0) begin
            note_failure($sformatf("result with nothing expected: %p", got));
        end else begin
            want = expected_steps.pop_front();
            check_field("transitioned", want.transitioned, got.transitioned, want.prior_node);
            check_field("finished", want.finished, got.finished, want.prior_node);
            check_field("prior_node", want.prior_node, got.prior_node, want.prior_node);
            check_field("next_node", want.next_node, got.next_node, want.prior_node);
            check_field("action_count", want.action_count, got.action_count, want.prior_node);
            check_field("first_action", want.first_action, got.first_action, want.prior_node);
            check_field("first_target", want.first_target, got.first_target, want.prior_node);
            check_field("second_action", want.second_action, got.second_action,
                        want.prior_node);
            check_field("second_target", want.second_target, got.second_target,
                        want.prior_node);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (i_valid && !o_stall) begin
                ctg_pkg::t_result r;
                r = advance_machine(dut_state, driven_item);
                expected_steps.insert(expected_steps.size(), r);
                if (driven_item.kind == ctg_pkg::KIND_START)
                    n_starts++;
                else if (!r.transitioned)
                    n_ignored++;
                if (r.finished)
                    n_completed++;
                if (r.action_count == 2'd2)
                    n_dual++;
                if (dut_state.depth != 0)
                    n_nested++;
            end
            if (!i_valid || !o_stall) begin
                if (hold_cycles > 0) begin
                    hold_cycles--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    driven_item = pending_items.pop_front();
                    i_kind <= driven_item.kind;
                    i_graph_select <= driven_item.graph_select;
                    i_event_code <= driven_item.event_code;
                    i_slc_hit <= driven_item.slc_hit;
                    i_sf_hit <= driven_item.sf_hit;
                    i_order_nonzero <= driven_item.order_nonzero;
                    i_valid <= 1'b1;
                    hold_cycles = draw_wait(send_mode);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_cycles = 0;
        end else begin
            if (o_valid && !i_stall) begin
                check_step();
                stall_cycles = draw_wait(recv_mode);
            end else if (stall_cycles > 0) begin
                stall_cycles--;
            end
            i_stall <= (stall_cycles > 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_steps.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        ctg_pkg::t_item it;
        int             roll;

        // events before any start, unused event code
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_SNP_CI, ctg_pkg::EV_ENTER, 1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_SNP_CI, EV_UNUSED, 1'b1, 1'b1, 1'b1);
        // ReadUnique through a nested McRead, guard mismatch first, events after exit
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_READ_UNIQUE, EV_UNUSED, 1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_ENTER,
            1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_SLC_DONE,
            1'b0, 1'b1, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_SLC_DONE,
            1'b0, 1'b0, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_READ_RCPT,
            1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_COMP_DATA,
            1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_COMP_ACK,
            1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_READ_UNIQUE, ctg_pkg::EV_COMP_ACK,
            1'b0, 1'b0, 1'b0);
        // CleanInvalid: hit/hit nested snoop, hit/miss direct exit, miss/hit nested
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_SLC_DONE,
            1'b1, 1'b1, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_SNP_RESP,
            1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_SLC_DONE,
            1'b1, 1'b0, 1'b1);
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_CLEAN_INV, ctg_pkg::EV_SLC_DONE,
            1'b0, 1'b1, 1'b0);
        // restart mid-transaction on McRead, then a top-level SnpCleanInvalid
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_MC_READ, ctg_pkg::EV_SNP_RESP, 1'b1, 1'b1, 1'b1);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_MC_READ, ctg_pkg::EV_ENTER, 1'b1, 1'b1, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_MC_READ, ctg_pkg::EV_COMP_DATA,
            1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_START, ctg_pkg::GS_SNP_CI, EV_UNUSED, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_SNP_CI, ctg_pkg::EV_ENTER, 1'b0, 1'b0, 1'b0);
        dir(ctg_pkg::KIND_EVENT, ctg_pkg::GS_SNP_CI, ctg_pkg::EV_SNP_RESP, 1'b0, 1'b0, 1'b0);

        // mostly well-formed walks with random guards, some noise and restarts
        repeat (RandomItems) begin
            it.graph_select = 2'($urandom);
            it.event_code = 3'($urandom);
            it.slc_hit = 1'($urandom);
            it.sf_hit = 1'($urandom);
            it.order_nonzero = 1'($urandom);
            roll = $urandom_range(0, 99);
            if (!gen_state.loaded || gen_state.complete) begin
                it.kind = (roll < 15) ? ctg_pkg::KIND_EVENT : ctg_pkg::KIND_START;
            end else if (roll < 6) begin
                it.kind = ctg_pkg::KIND_START;
            end else begin
                it.kind = ctg_pkg::KIND_EVENT;
                if (roll >= 16)
                    it.event_code = awaited_event(gen_state.node);
            end
            queue_item(it);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d starts, %0d completed transactions, %0d ignored events",
                 n_starts, n_completed, n_ignored);
        $display("%0d steps emitted two actions, %0d steps ended inside a child graph",
                 n_dual, n_nested);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", failures);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ctg_pkg.sv
hdl/ctg_step.sv
hdl/coherence_transaction_graph_fsm_top.sv
tb/tb_coherence_transaction_graph_fsm_top.sv
